/* hdl/ler_pkg.sv */
`timescale 1ns / 1ps

package ler_pkg;

   // Datapath widths. The gain-scaled offset carries 16 guard bits below
   // the Q16.16 point and stays under 2^49 through all micro-rotations.
   localparam int XY_W = 52;
   // Angle in Q32 radians, at most about pi/2 in magnitude.
   localparam int Z_W = 35;

   // Degree constants in Q16.16.
   localparam logic [24:0] DEG_FULL     = 25'd23592960;
   localparam logic [24:0] DEG_HALF     = 25'd11796480;
   localparam logic [24:0] DEG_QUARTER  = 25'd5898240;
   localparam logic [24:0] DEG_3QUARTER = 25'd17694720;

   // Inverse CORDIC gain in Q30.
   localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

   // Reduction of whole degrees modulo 360: the integer part is biased by
   // 92 turns so it is never negative, then divided by a reciprocal.
   localparam logic [16:0] DEG_BIAS   = 17'd33120;
   localparam logic [12:0] RECIP_360  = 13'd5825;
   localparam logic [16:0] DEG_TURN   = 17'd360;

   localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] angle_deg;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] new_end_x;
      logic signed [31:0] new_end_y;
      logic               saturated;
   } rsp_word_type;

   typedef struct packed {
      logic signed [31:0] sx;
      logic signed [31:0] sy;
   } pivot_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      pivot_type              pivot;
   } cordic_word_type;

   // Unsigned 64-bit quotient by restoring long division, used only while
   // the constant tables are built.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = 64'd0;
      rem = 65'd0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(2^-i) in Q60 by the alternating series, for i of one or more.
   function automatic logic [63:0] atan_pow2_q60(input int unsigned i);
      logic [63:0] p;
      logic [63:0] sum;
      logic [63:0] k;
      logic        sub;
      p   = ONE_Q60 >> i;
      sum = 64'd0;
      k   = 64'd1;
      sub = 1'b0;
      while (p != 64'd0) begin
         if (sub) begin
            sum = sum - udiv64(p, k);
         end else begin
            sum = sum + udiv64(p, k);
         end
         sub = !sub;
         k   = k + 64'd2;
         p   = p >> (2 * i);
      end
      return sum;
   endfunction

   // atan(1/3) in Q60 by the same series.
   function automatic logic [63:0] atan_inv3_q60();
      logic [63:0] p;
      logic [63:0] sum;
      logic [63:0] k;
      logic        sub;
      p   = udiv64(ONE_Q60, 64'd3);
      sum = 64'd0;
      k   = 64'd1;
      sub = 1'b0;
      while (p != 64'd0) begin
         if (sub) begin
            sum = sum - udiv64(p, k);
         end else begin
            sum = sum + udiv64(p, k);
         end
         sub = !sub;
         k   = k + 64'd2;
         p   = udiv64(p, 64'd9);
      end
      return sum;
   endfunction

   localparam logic [63:0] QUARTER_PI_Q60 = atan_pow2_q60(1) + atan_inv3_q60();

   // pi/180 in Q40.
   localparam logic signed [35:0] RAD_PER_DEG_Q40 =
      36'((((64'd4 * QUARTER_PI_Q60) / 180) + (64'd1 << 19)) >> 20);

   // Micro-rotation angle of step i, Q32 radians, rounded.
   function automatic logic [31:0] atan_q32(input int unsigned i);
      logic [63:0] full;
      full = (i == 0) ? QUARTER_PI_Q60 : atan_pow2_q60(i);
      return 32'((full + (64'd1 << 27)) >> 28);
   endfunction

endpackage

/* hdl/ler_prep.sv */
`timescale 1ns / 1ps

module ler_prep (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  ler_pkg::req_word_type    in_word,
   output logic                     out_valid,
   output ler_pkg::cordic_word_type out_word
);

   localparam int XW = ler_pkg::XY_W;
   localparam int ZW = ler_pkg::Z_W;

   logic [5:0] vld_ff, vld_in;
   ler_pkg::pivot_type pivot_ff [0:5];

   // Stage 1: offsets and biased whole degrees.
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [16:0] u1_ff, u1_in;
   logic [15:0] lo1_ff;

   // Stage 2: products.
   logic signed [63:0] px_ff, px_in, py_ff, py_in;
   logic [29:0] pu_ff, pu_in;
   logic [16:0] u2_ff;
   logic [15:0] lo2_ff;

   // Stage 3: reduced angle and scaled offset.
   logic [8:0] qe;
   logic [16:0] rem_full, rem_fix;
   logic [24:0] a3_ff, a3_in;
   logic signed [XW-1:0] x3_ff, y3_ff;

   // Stage 4: folded angle and quarter turn.
   logic signed [25:0] a_s;
   logic signed [25:0] ang_full;
   logic signed [23:0] ang4_ff;
   logic signed [XW-1:0] x4_ff, x4_in, y4_ff, y4_in;

   // Stage 5 and 6: conversion to radians.
   logic signed [59:0] pz5_ff, pz5_in, pz_round;
   logic signed [XW-1:0] x5_ff, y5_ff, x6_ff, y6_ff;
   logic signed [ZW-1:0] z6_ff;

   assign vld_in = {vld_ff[4:0], in_valid};

   assign dx_in = 33'(in_word.end_x) - 33'(in_word.start_x);
   assign dy_in = 33'(in_word.end_y) - 33'(in_word.start_y);
   assign u1_in = 17'($signed(in_word.angle_deg[31:16])) + ler_pkg::DEG_BIAS;

   assign px_in = 64'(dx_ff) * 64'(ler_pkg::GAIN_Q30);
   assign py_in = 64'(dy_ff) * 64'(ler_pkg::GAIN_Q30);
   assign pu_in = 30'(u1_ff) * 30'(ler_pkg::RECIP_360);

   // The reciprocal estimate is the true quotient or one less, so one
   // conditional subtract finishes the remainder.
   assign qe       = pu_ff[29:21];
   assign rem_full = u2_ff - 17'(qe) * ler_pkg::DEG_TURN;
   assign rem_fix  = (rem_full >= ler_pkg::DEG_TURN) ? rem_full - ler_pkg::DEG_TURN
                                                     : rem_full;
   assign a3_in    = {rem_fix[8:0], lo2_ff};

   always_comb begin
      a_s = $signed({1'b0, a3_ff});
      if (a3_ff <= ler_pkg::DEG_QUARTER) begin
         ang_full = a_s;
         x4_in    = x3_ff;
         y4_in    = y3_ff;
      end else if (a3_ff <= ler_pkg::DEG_HALF) begin
         ang_full = a_s - $signed({1'b0, ler_pkg::DEG_QUARTER});
         x4_in    = -y3_ff;
         y4_in    = x3_ff;
      end else if (a3_ff < ler_pkg::DEG_3QUARTER) begin
         ang_full = a_s - $signed({1'b0, ler_pkg::DEG_3QUARTER});
         x4_in    = y3_ff;
         y4_in    = -x3_ff;
      end else begin
         ang_full = a_s - $signed({1'b0, ler_pkg::DEG_FULL});
         x4_in    = x3_ff;
         y4_in    = y3_ff;
      end
   end

   assign pz5_in   = 60'(ang4_ff) * 60'(ler_pkg::RAD_PER_DEG_Q40);
   assign pz_round = pz5_ff + 60'sd8388608;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pivot_ff[0] <= '{sx: in_word.start_x, sy: in_word.start_y};
         for (int s = 1; s < 6; s++) begin
            pivot_ff[s] <= pivot_ff[s-1];
         end
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         u1_ff   <= u1_in;
         lo1_ff  <= in_word.angle_deg[15:0];
         px_ff   <= px_in;
         py_ff   <= py_in;
         pu_ff   <= pu_in;
         u2_ff   <= u1_ff;
         lo2_ff  <= lo1_ff;
         a3_ff   <= a3_in;
         x3_ff   <= XW'(px_ff >>> 14);
         y3_ff   <= XW'(py_ff >>> 14);
         ang4_ff <= ang_full[23:0];
         x4_ff   <= x4_in;
         y4_ff   <= y4_in;
         pz5_ff  <= pz5_in;
         x5_ff   <= x4_ff;
         y5_ff   <= y4_ff;
         z6_ff   <= pz_round[24 +: ZW];
         x6_ff   <= x5_ff;
         y6_ff   <= y5_ff;
      end
   end

   assign out_valid      = vld_ff[5];
   assign out_word.x     = x6_ff;
   assign out_word.y     = y6_ff;
   assign out_word.z     = z6_ff;
   assign out_word.pivot = pivot_ff[5];

endmodule

/* hdl/ler_cell.sv */
`timescale 1ns / 1ps

module ler_cell #(
   parameter int unsigned STAGE = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  ler_pkg::cordic_word_type in_word,
   output logic                     out_valid,
   output ler_pkg::cordic_word_type out_word
);

   localparam logic [31:0] ATAN_RAW = ler_pkg::atan_q32(STAGE);

   logic signed [ler_pkg::Z_W-1:0]  atan_step;
   logic signed [ler_pkg::XY_W-1:0] xs, ys;
   logic valid_ff;
   ler_pkg::cordic_word_type word_ff, word_in;

   assign atan_step = $signed({{(ler_pkg::Z_W-32){1'b0}}, ATAN_RAW});
   assign xs = in_word.x >>> STAGE;
   assign ys = in_word.y >>> STAGE;

   // Turn toward zero residual angle.
   always_comb begin
      word_in.pivot = in_word.pivot;
      if (!in_word.z[ler_pkg::Z_W-1]) begin
         word_in.x = in_word.x - ys;
         word_in.y = in_word.y + xs;
         word_in.z = in_word.z - atan_step;
      end else begin
         word_in.x = in_word.x + ys;
         word_in.y = in_word.y - xs;
         word_in.z = in_word.z + atan_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

/* hdl/ler_post.sv */
`timescale 1ns / 1ps

module ler_post (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  ler_pkg::cordic_word_type in_word,
   output logic                     rsp_valid,
   output ler_pkg::rsp_word_type    rsp_word
);

   localparam logic signed [36:0] SAT_HI = 37'sd2147483647;
   localparam logic signed [36:0] SAT_LO = -37'sd2147483648;

   logic [1:0] vld_ff, vld_in;
   logic signed [ler_pkg::XY_W-1:0] xsum, ysum;
   logic signed [35:0] xr_ff, yr_ff;
   ler_pkg::pivot_type pivot_ff;
   logic signed [36:0] fx, fy;
   logic clip_x, clip_y;
   ler_pkg::rsp_word_type rsp_ff, rsp_in;

   assign vld_in = {vld_ff[0], in_valid};

   // Round away the 16 guard bits, half up.
   assign xsum = in_word.x + ler_pkg::XY_W'(32768);
   assign ysum = in_word.y + ler_pkg::XY_W'(32768);

   assign fx = 37'(pivot_ff.sx) + 37'(xr_ff);
   assign fy = 37'(pivot_ff.sy) + 37'(yr_ff);

   always_comb begin
      clip_x = 1'b1;
      clip_y = 1'b1;
      if (fx > SAT_HI) begin
         rsp_in.new_end_x = SAT_HI[31:0];
      end else if (fx < SAT_LO) begin
         rsp_in.new_end_x = SAT_LO[31:0];
      end else begin
         rsp_in.new_end_x = fx[31:0];
         clip_x = 1'b0;
      end
      if (fy > SAT_HI) begin
         rsp_in.new_end_y = SAT_HI[31:0];
      end else if (fy < SAT_LO) begin
         rsp_in.new_end_y = SAT_LO[31:0];
      end else begin
         rsp_in.new_end_y = fy[31:0];
         clip_y = 1'b0;
      end
      rsp_in.saturated = clip_x | clip_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xr_ff    <= xsum[16 +: 36];
         yr_ff    <= ysum[16 +: 36];
         pivot_ff <= in_word.pivot;
         rsp_ff   <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff[1];
   assign rsp_word  = rsp_ff;

endmodule

/* hdl/line_endpoint_rotation_top.sv */
// Depth: the pipeline holds CORDIC_STAGES + 8 registers, and a word accepted on req passes
// through each of them in order, front end, CORDIC cells and back end, before it leaves on rsp.
// Throughput: one word per cycle unless stalled; each stage and each CORDIC step is its own register.
// The pipeline advances as a whole and stalls only while the rsp word is held by rsp_ready low.
// Reset is synchronous and active high; it clears every valid bit, data registers keep their contents.
`timescale 1ns / 1ps

module line_endpoint_rotation_top #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ler_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ler_pkg::rsp_word_type rsp_word
);

   // The whole pipeline moves forward whenever the output register is
   // empty or its word is being taken this cycle. Because req_ready follows
   // the same signal, a new word can enter while the previous result waits
   // in the output register, as long as that result leaves in this cycle.
   logic adv;

   // One valid bit and one data word per link of the CORDIC chain; link 0
   // is the output of the front end, the last link feeds the back end.
   logic [CORDIC_STAGES:0] chain_valid;
   ler_pkg::cordic_word_type chain_word [0:CORDIC_STAGES];

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // Front end, six stages: offset from the pivot, scaling by the inverse
   // CORDIC gain, reduction of the angle modulo 360 degrees, folding into
   // plus or minus 90 degrees with an exact quarter turn of the offset,
   // and conversion of the angle to Q32 radians.
   ler_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_word   (req_word),
      .out_valid (chain_valid[0]),
      .out_word  (chain_word[0])
   );

   // The CORDIC chain: each cell does one micro-rotation with its own shift
   // and arctangent constant and passes the rotated vector to the next.
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      ler_cell #(
         .STAGE (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (chain_valid[i]),
         .in_word   (chain_word[i]),
         .out_valid (chain_valid[i+1]),
         .out_word  (chain_word[i+1])
      );
   end

   // Back end, two stages: rounding to Q16.16, adding the pivot back and
   // clamping to the 32-bit range, then the output register.
   ler_post u_post (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (chain_valid[CORDIC_STAGES]),
      .in_word   (chain_word[CORDIC_STAGES]),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // Ready drops only because the output word is being held.
   a_ready_low_only_on_stall : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req_ready low without a held rsp word");

   // A held output freezes every valid bit of the CORDIC chain.
   a_chain_frozen_on_stall : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(chain_valid))
      else $error("CORDIC chain moved while the output was held");

   // The clamp flag is set only together with a coordinate at a bound.
   a_sat_flag_has_bound : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.saturated) |->
         (rsp_word.new_end_x == 32'sh7FFFFFFF || rsp_word.new_end_x == 32'sh80000000 ||
          rsp_word.new_end_y == 32'sh7FFFFFFF || rsp_word.new_end_y == 32'sh80000000))
      else $error("saturated set with no coordinate at a bound");

   // Nothing comes out in the cycle after reset.
   a_empty_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

endmodule

/* verif/line_endpoint_rotation_top_tb.sv */
`timescale 1ns / 1ps

// Testbench for the line endpoint rotation pipeline. A predictor written in
// plain 64-bit integer arithmetic works out the rotated end point of every
// word that the block accepts. A checker process compares each result word
// against the oldest prediction still waiting.
module line_endpoint_rotation_top_tb;

   // The pipeline depth follows the CORDIC length, plus eight fixed stages.
   localparam int ROT_STAGES  = 24;
   localparam int PIPE_DEPTH  = ROT_STAGES + 8;
   localparam int HOLD_CYCLES = 300;

   // Q16.16 scale for both coordinates and degrees.
   localparam int ONE = 65536;

   // Degree constants in Q16.16 and the inverse CORDIC gain in Q30.
   localparam longint TURN_FULL    = 64'sd23592960;
   localparam longint TURN_HALF    = 64'sd11796480;
   localparam longint TURN_QUARTER = 64'sd5898240;
   localparam longint GAIN_K       = 64'sd652032874;
   localparam longint COORD_MAX    = 64'sd2147483647;
   localparam longint COORD_MIN    = -COORD_MAX - 64'sd1;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   ler_pkg::req_word_type req_word;
   logic                  rsp_valid;
   logic                  rsp_ready;
   ler_pkg::rsp_word_type rsp_word;

   // Predicted result words, oldest first.
   ler_pkg::rsp_word_type predicted_rotations[$];
   ler_pkg::rsp_word_type oldest_rotation;

   int unsigned failures       = 0;
   int unsigned words_sent     = 0;
   int unsigned words_checked  = 0;
   int unsigned clamped_seen   = 0;

   // Knobs that the tests turn to shape the traffic on both sides.
   bit          sender_gaps_on  = 1'b1;
   bit          rsp_stalls_on   = 1'b1;
   bit          hold_off_request = 1'b0;
   int unsigned hold_count;

   line_endpoint_rotation_top #(
      .CORDIC_STAGES(ROT_STAGES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The run ends here if the pipeline ever hangs.
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   // ----------------------------------------------------------------------
   // Prediction
   // ----------------------------------------------------------------------

   // Arctangent of 1/n in Q60 by the alternating power series.
   function automatic longint unsigned atan_recip_q60(input longint unsigned n);
      longint unsigned p;
      longint unsigned n2;
      longint unsigned sum;
      longint unsigned k;
      longint unsigned term;
      bit              sub;
      p   = (64'd1 << 60) / n;
      n2  = n * n;
      sum = 64'd0;
      k   = 64'd1;
      sub = 1'b0;
      while (p != 64'd0) begin
         term = p / k;
         sum  = sub ? sum - term : sum + term;
         sub  = !sub;
         k    = k + 64'd2;
         p    = p / n2;
      end
      return sum;
   endfunction

   // Rotates the end point about the start point and rounds and clamps the
   // result exactly as the fixed-point datapath does.
   function automatic ler_pkg::rsp_word_type rotate_endpoint(input ler_pkg::req_word_type w);
      longint                atan_step[ROT_STAGES];
      longint unsigned       quarter_pi;
      longint                rad_per_deg;
      longint                sx;
      longint                sy;
      longint                x;
      longint                y;
      longint                z;
      longint                ang;
      longint                swap;
      longint                xs;
      longint                ys;
      longint                rx;
      longint                ry;
      bit                    clamp;
      ler_pkg::rsp_word_type r;
      quarter_pi   = atan_recip_q60(64'd2) + atan_recip_q60(64'd3);
      rad_per_deg  = longint'((((64'd4 * quarter_pi) / 180) + (64'd1 << 19)) >> 20);
      atan_step[0] = longint'((quarter_pi + (64'd1 << 27)) >> 28);
      for (int i = 1; i < ROT_STAGES; i++) begin
         atan_step[i] = longint'((atan_recip_q60(64'd1 << i) + (64'd1 << 27)) >> 28);
      end

      sx = w.start_x;
      sy = w.start_y;
      // The offset is exact in 33 bits and carries the gain and 16 guard bits.
      x  = ((longint'(w.end_x) - sx) * GAIN_K) >>> 14;
      y  = ((longint'(w.end_y) - sy) * GAIN_K) >>> 14;

      // Reduce to (-180, 180] degrees, then fold into [-90, 90] by a quarter turn.
      ang = longint'(w.angle_deg) % TURN_FULL;
      if (ang < 0) begin
         ang = ang + TURN_FULL;
      end
      if (ang > TURN_HALF) begin
         ang = ang - TURN_FULL;
      end
      if (ang > TURN_QUARTER) begin
         swap = x;
         x    = -y;
         y    = swap;
         ang  = ang - TURN_QUARTER;
      end else if (ang < -TURN_QUARTER) begin
         swap = x;
         x    = y;
         y    = -swap;
         ang  = ang + TURN_QUARTER;
      end

      z = (ang * rad_per_deg + 64'sd8388608) >>> 24;

      for (int i = 0; i < ROT_STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - atan_step[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + atan_step[i];
         end
      end

      clamp = 1'b0;
      rx    = sx + ((x + 64'sd32768) >>> 16);
      ry    = sy + ((y + 64'sd32768) >>> 16);
      if (rx > COORD_MAX) begin
         rx    = COORD_MAX;
         clamp = 1'b1;
      end else if (rx < COORD_MIN) begin
         rx    = COORD_MIN;
         clamp = 1'b1;
      end
      if (ry > COORD_MAX) begin
         ry    = COORD_MAX;
         clamp = 1'b1;
      end else if (ry < COORD_MIN) begin
         ry    = COORD_MIN;
         clamp = 1'b1;
      end

      r.new_end_x = 32'(rx);
      r.new_end_y = 32'(ry);
      r.saturated = clamp;
      return r;
   endfunction

   // ----------------------------------------------------------------------
   // Stimulus helpers
   // ----------------------------------------------------------------------

   // Most gaps are short; now and then one is long.
   function automatic int unsigned gap_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         return 0;
      end else if (pick < 90) begin
         return $urandom_range(1, 3);
      end else if (pick < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   // A coordinate drawn from the full range, from near zero, from within 2^28 of zero, or from near
   // either rail, so that both small offsets and clamping turn up.
   function automatic logic signed [31:0] random_coord();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6:    return $urandom_range(0, 2 * 1048576) - 1048576;
         7:          return 32'h7FFF_FFFF - $urandom_range(0, 4 * ONE);
         8:          return 32'h8000_0000 + $urandom_range(0, 4 * ONE);
         default:    return $urandom_range(0, 2 * 268435456) - 268435456;
      endcase
   endfunction

   // An angle drawn from the full range, close to a multiple of a quarter
   // turn, or within one turn either way.
   function automatic logic signed [31:0] random_angle();
      int k;
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom;
         3, 4, 5: begin
            k = $urandom_range(0, 16);
            return (k - 8) * int'(TURN_QUARTER) + $urandom_range(0, 6) - 3;
         end
         6, 7:    return $urandom_range(0, 2 * int'(TURN_FULL)) - int'(TURN_FULL);
         8: begin
            k = $urandom_range(0, 20);
            return (k - 10) * int'(TURN_HALF);
         end
         default: return $urandom_range(0, 4 * ONE) - 2 * ONE;
      endcase
   endfunction

   // Offers one word and returns at the clock edge where it is accepted.
   // Valid is left high, so a word that follows at once keeps it steady.
   task automatic send_word(input logic signed [31:0] sx, input logic signed [31:0] sy,
                            input logic signed [31:0] ex, input logic signed [31:0] ey,
                            input logic signed [31:0] ang);
      ler_pkg::req_word_type w;
      w.start_x   = sx;
      w.start_y   = sy;
      w.end_x     = ex;
      w.end_y     = ey;
      w.angle_deg = ang;
      req_valid <= 1'b1;
      req_word  <= w;
      do begin
         @(posedge clock);
      end while (!req_ready);
      predicted_rotations.push_back(rotate_endpoint(w));
      words_sent++;
   endtask

   // Drops valid for a number of cycles; a zero gap leaves it untouched.
   task automatic sender_idle(input int unsigned n);
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Stops offering and waits until every predicted word has come back.
   // It waits on the clock before it first checks the queue, so valid is
   // never lowered and raised in the same step.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_rotations.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // ----------------------------------------------------------------------
   // Tests
   // ----------------------------------------------------------------------

   // Field extremes, every quarter turn, the half turn, the edges of the
   // fold at plus and minus ninety degrees, a zero offset and clamping.
   task automatic test_directed();
      send_word(0, 0, ONE, 0, 0);
      sender_idle(gap_length());
      send_word(0, 0, ONE, 0, 90 * ONE);
      sender_idle(gap_length());
      send_word(0, 0, ONE, 0, 180 * ONE);
      sender_idle(gap_length());
      send_word(0, 0, ONE, 0, 270 * ONE);
      sender_idle(gap_length());
      send_word(0, 0, ONE, 0, -90 * ONE);
      sender_idle(gap_length());
      send_word(0, 0, ONE, 0, -180 * ONE);
      sender_idle(gap_length());
      send_word(0, 0, ONE, 0, 360 * ONE);
      sender_idle(gap_length());
      send_word(5 * ONE, -3 * ONE, 7 * ONE, 2 * ONE, 45 * ONE);
      sender_idle(gap_length());
      // Just either side of the fold points.
      send_word(ONE, ONE, 3 * ONE, -ONE, 90 * ONE + 1);
      send_word(ONE, ONE, 3 * ONE, -ONE, 90 * ONE - 1);
      send_word(ONE, ONE, 3 * ONE, -ONE, -90 * ONE - 1);
      send_word(ONE, ONE, 3 * ONE, -ONE, -90 * ONE + 1);
      send_word(-ONE, 2 * ONE, 4 * ONE, 7 * ONE, 180 * ONE + 1);
      send_word(-ONE, 2 * ONE, 4 * ONE, 7 * ONE, -180 * ONE - 1);
      sender_idle(gap_length());
      // The angle field at both rails.
      send_word(0, 0, 100 * ONE, 50 * ONE, 32'h7FFF_FFFF);
      send_word(0, 0, 100 * ONE, 50 * ONE, 32'h8000_0000);
      // A zero offset stays on the pivot.
      send_word(12345, -678, 12345, -678, 30 * ONE);
      sender_idle(gap_length());
      // Offsets of 33 bits and small offsets at a rail, most rotated so that the result runs off a rail.
      send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 180 * ONE);
      send_word(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 180 * ONE);
      send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 90 * ONE);
      send_word(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF - ONE, 0, 0);
      send_word(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, ONE, -90 * ONE);
      sender_idle(gap_length());
      // Every field all ones, all at the top and all at the bottom.
      send_word(-1, -1, -1, -1, -1);
      send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF);
      send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000);
   endtask

   // A long random stream. Every few dozen words the idling on each side
   // is switched on or off, so some stretches run at full rate.
   task automatic test_random_stream();
      for (int i = 0; i < 300; i++) begin
         if (i % 40 == 0) begin
            sender_gaps_on = ($urandom_range(0, 3) != 0);
            rsp_stalls_on  = ($urandom_range(0, 3) != 0);
         end
         send_word(random_coord(), random_coord(), random_coord(), random_coord(),
                   random_angle());
         if (sender_gaps_on) begin
            sender_idle(gap_length());
         end
      end
      rsp_stalls_on = 1'b1;
   endtask

   // The receiver holds off for a long stretch while words keep coming,
   // so the pipeline fills and stalls the request side.
   task automatic test_output_hold_off();
      hold_off_request = 1'b1;
      for (int i = 0; i < 80; i++) begin
         send_word(random_coord(), random_coord(), random_coord(), random_coord(),
                   random_angle());
      end
   endtask

   // The sender stops until every prediction has been met, then goes on.
   task automatic test_drain_pause();
      for (int i = 0; i < 10; i++) begin
         send_word(random_coord(), random_coord(), random_coord(), random_coord(),
                   random_angle());
         sender_idle(gap_length());
      end
      wait_for_drain();
      for (int i = 0; i < 10; i++) begin
         send_word(random_coord(), random_coord(), random_coord(), random_coord(),
                   random_angle());
      end
   endtask

   // ----------------------------------------------------------------------
   // Result side
   // ----------------------------------------------------------------------

   // Ready is driven here alone. A requested hold-off is counted out in
   // cycles; otherwise ready drops now and then for a random gap.
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
               @(posedge clock);
            end
         end else if (rsp_stalls_on && $urandom_range(0, 99) < 25) begin
            rsp_ready <= 1'b0;
            repeat (gap_length() + 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Each accepted result word is checked against the oldest prediction.
   // Values are read at the edge, before any of this edge's updates land.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (predicted_rotations.size() == 0) begin
            $error("result word arrived with no prediction waiting: %h", rsp_word);
            failures++;
         end else begin
            oldest_rotation = predicted_rotations.pop_front();
            words_checked++;
            if (rsp_word.saturated === 1'b1) begin
               clamped_seen++;
            end
            if (rsp_word.new_end_x !== oldest_rotation.new_end_x) begin
               $error("new_end_x: expected %0d, got %0d",
                      oldest_rotation.new_end_x, rsp_word.new_end_x);
               failures++;
            end
            if (rsp_word.new_end_y !== oldest_rotation.new_end_y) begin
               $error("new_end_y: expected %0d, got %0d",
                      oldest_rotation.new_end_y, rsp_word.new_end_y);
               failures++;
            end
            if (rsp_word.saturated !== oldest_rotation.saturated) begin
               $error("saturated: expected %0b, got %0b",
                      oldest_rotation.saturated, rsp_word.saturated);
               failures++;
            end
         end
      end
   end

   // ----------------------------------------------------------------------
   // Sequence of the run
   // ----------------------------------------------------------------------

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_stream();
      test_output_hold_off();
      test_drain_pause();

      // Everything has been accepted; let the pipeline empty out.
      wait_for_drain();
      repeat (PIPE_DEPTH + 8) @(posedge clock);

      if (predicted_rotations.size() != 0) begin
         $error("%0d predicted words never arrived", predicted_rotations.size());
         failures++;
      end

      $display("Run covered %0d rotation words, %0d checked, %0d of them clamped,",
               words_sent, words_checked, clamped_seen);
      $display("with random gaps, a %0d-cycle output hold-off and a full drain pause.",
               HOLD_CYCLES);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/ler_pkg.sv
hdl/ler_prep.sv
hdl/ler_cell.sv
hdl/ler_post.sv
hdl/line_endpoint_rotation_top.sv
verif/line_endpoint_rotation_top_tb.sv
